// ----- rtl/shs_pkg.sv -----
// Package for the stepper homing sequencer: phase codes, register indexes,
// reset values and the microstep pin table. No dependencies.
`default_nettype none

package shs_pkg;

    // Widths of the fixed configuration and channel fields
    localparam int HALF_W      = 16;
    localparam int BACKOFF_W   = 16;
    localparam int DEB_CFG_W   = 24;
    localparam int MODE_W      = 3;
    localparam int PHASE_W     = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // Default parameter values
    localparam int TIMER_WIDTH_DEF    = 16;
    localparam int DEBOUNCE_WIDTH_DEF = 24;

    // Register reset values
    localparam int SWITCH_SETTLE_MSEC = 260;
    localparam logic [HALF_W-1:0]    FAST_HALF_RST = HALF_W'(4000);
    localparam logic [HALF_W-1:0]    SLOW_HALF_RST = HALF_W'(5000);
    localparam logic [BACKOFF_W-1:0] BACKOFF_RST   = BACKOFF_W'(200);
    localparam logic [DEB_CFG_W-1:0] DEBOUNCE_RST  = DEB_CFG_W'(SWITCH_SETTLE_MSEC * 1000);
    localparam logic [MODE_W-1:0]    MODE_RST      = MODE_W'(4);

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FAST_HALF = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOW_HALF = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKOFF   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE      = 3'd4;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_FAST = 3'd1;
    localparam logic [PHASE_W-1:0] PH_BACK = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SLOW = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE = 3'd4;

    // Microstep modes
    localparam logic [MODE_W-1:0] MODE_FULL      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HALF      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_QUARTER   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EIGHTH    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SIXTEENTH = 3'd4;

    typedef struct packed {
        logic                step_out;
        logic                dir_out;
        logic                mode_pin_one;
        logic                mode_pin_two;
        logic                mode_pin_three;
        logic [PHASE_W-1:0]  phase;
        logic                edge_accepted;
        logic                homing_finished;
    } result_t;

    // Returns {pin one, pin two, pin three}; undefined modes act as full step
    function automatic logic [2:0] mode_pins(input logic [MODE_W-1:0] mode);
        logic [2:0] pins;
        case (mode)
            MODE_FULL:      pins = 3'b000;
            MODE_HALF:      pins = 3'b100;
            MODE_QUARTER:   pins = 3'b010;
            MODE_EIGHTH:    pins = 3'b110;
            MODE_SIXTEENTH: pins = 3'b111;
            default:        pins = 3'b000;
        endcase
        return pins;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/shs_ifs.sv -----
// Channel interfaces of the stepper homing sequencer: tick, result and
// configuration write. No dependencies.
`default_nettype none

interface shs_tick_if;
    logic valid;
    logic ready;
    logic limit_level;
    logic start_request;

    modport source (output valid, output limit_level, output start_request, input ready);
    modport sink   (input valid, input limit_level, input start_request, output ready);
endinterface

interface shs_result_if;
    logic       valid;
    logic       ready;
    logic       step_out;
    logic       dir_out;
    logic       mode_pin_one;
    logic       mode_pin_two;
    logic       mode_pin_three;
    logic [2:0] phase;
    logic       edge_accepted;
    logic       homing_finished;

    modport source (output valid, output step_out, output dir_out, output mode_pin_one,
                    output mode_pin_two, output mode_pin_three, output phase,
                    output edge_accepted, output homing_finished, input ready);
    modport sink   (input valid, input step_out, input dir_out, input mode_pin_one,
                    input mode_pin_two, input mode_pin_three, input phase,
                    input edge_accepted, input homing_finished, output ready);
endinterface

interface shs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/shs_debounce.sv -----
// Limit switch debouncer: accepts a falling edge only when more than the
// debounce time has elapsed since the last accepted edge. Depends on shs_pkg.
`default_nettype none

module shs_debounce
    import shs_pkg::*;
#(
    parameter int DEBOUNCE_WIDTH = DEBOUNCE_WIDTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire logic                 level,
    input  wire logic [DEB_CFG_W-1:0] debounce_ticks,
    output      logic                 accepted
);

    localparam int CMP_W = (DEBOUNCE_WIDTH > DEB_CFG_W) ? DEBOUNCE_WIDTH : DEB_CFG_W;
    localparam logic [DEBOUNCE_WIDTH-1:0] DEB_MAX = '1;

    logic                      prev_level_reg;
    logic [DEBOUNCE_WIDTH-1:0] ticks_reg;
    logic [DEBOUNCE_WIDTH-1:0] elapsed;

    always_comb
    begin
        elapsed  = (ticks_reg == DEB_MAX) ? ticks_reg : ticks_reg + 1'b1;
        accepted = prev_level_reg && !level
                   && (CMP_W'(elapsed) > CMP_W'(debounce_ticks));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b1;
            ticks_reg      <= '0;
        end
        else if (advance)
        begin
            prev_level_reg <= level;
            ticks_reg      <= accepted ? '0 : elapsed;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/stepper_homing_sequencer_core.sv -----
// A tick request is held in the input register, then its result in the result register.
// Throughput: one tick per cycle while the result is not stalled; the result register
// frees as it is read, so ticks keep flowing while it is taken.
// Reset (rst_n, async low): idle phase, step low, direction toward switch,
// switch taken as released, configuration registers at their defaults.
`default_nettype none

module stepper_homing_sequencer_core
    import shs_pkg::*;
#(
    parameter int TIMER_WIDTH    = TIMER_WIDTH_DEF,
    parameter int DEBOUNCE_WIDTH = DEBOUNCE_WIDTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    shs_tick_if.sink    tick,
    shs_cfg_if.sink     cfg,
    shs_result_if.source result
);

    localparam int HCMP_W = (TIMER_WIDTH > HALF_W) ? TIMER_WIDTH : HALF_W;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

    // Configuration registers
    logic [HALF_W-1:0]    fast_half_reg;
    logic [HALF_W-1:0]    slow_half_reg;
    logic [BACKOFF_W-1:0] backoff_reg;
    logic [DEB_CFG_W-1:0] debounce_reg;
    logic [MODE_W-1:0]    mode_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_half_reg <= FAST_HALF_RST;
            slow_half_reg <= SLOW_HALF_RST;
            backoff_reg   <= BACKOFF_RST;
            debounce_reg  <= DEBOUNCE_RST;
            mode_reg      <= MODE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_FAST_HALF: fast_half_reg <= cfg.data[HALF_W-1:0];
                REG_SLOW_HALF: slow_half_reg <= cfg.data[HALF_W-1:0];
                REG_BACKOFF:   backoff_reg   <= cfg.data[BACKOFF_W-1:0];
                REG_DEBOUNCE:  debounce_reg  <= cfg.data[DEB_CFG_W-1:0];
                REG_MODE:      mode_reg      <= cfg.data[MODE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Pipeline handshake
    logic    in_valid_reg;
    logic    in_level_reg;
    logic    in_start_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    advance;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick.ready)
                in_valid_reg <= tick.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            in_level_reg <= tick.limit_level;
            in_start_reg <= tick.start_request;
        end
    end

    // Debounce runs ahead of the sequencer within a tick
    logic accepted;

    shs_debounce #(
        .DEBOUNCE_WIDTH (DEBOUNCE_WIDTH)
    ) u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .level          (in_level_reg),
        .debounce_ticks (debounce_reg),
        .accepted       (accepted)
    );

    // Sequencer state
    logic [PHASE_W-1:0]     phase_reg,   phase_next;
    logic [TIMER_WIDTH-1:0] timer_reg,   timer_next;
    logic [TIMER_WIDTH-1:0] count_reg,   count_next;
    logic                   pulse_reg,   pulse_next;
    logic                   pressed_reg, pressed_next;
    logic                   dir_reg,     dir_next;
    logic                   finished;

    logic                   active;
    logic [HALF_W-1:0]      half;
    logic [TIMER_WIDTH-1:0] timer_inc;
    logic [TIMER_WIDTH-1:0] count_inc;
    logic                   expired;
    logic                   pressed_now;
    logic [2:0]             pins;

    always_comb
    begin
        active      = (phase_reg == PH_FAST) || (phase_reg == PH_BACK)
                      || (phase_reg == PH_SLOW);
        half        = (phase_reg == PH_SLOW) ? slow_half_reg : fast_half_reg;
        timer_inc   = (timer_reg == TIMER_MAX) ? timer_reg : timer_reg + 1'b1;
        count_inc   = (count_reg == TIMER_MAX) ? count_reg : count_reg + 1'b1;
        expired     = HCMP_W'(timer_inc) >= HCMP_W'(half);
        pressed_now = pressed_reg || accepted;

        phase_next   = phase_reg;
        timer_next   = timer_reg;
        count_next   = count_reg;
        pulse_next   = pulse_reg;
        pressed_next = pressed_now;
        dir_next     = dir_reg;
        finished     = 1'b0;

        if (active)
        begin
            if (!expired)
            begin
                timer_next = timer_inc;
            end
            else if (pulse_reg)
            begin
                pulse_next = 1'b0;
                timer_next = '0;
            end
            else
            begin
                // End of a whole step
                pulse_next = 1'b1;
                timer_next = '0;
                case (phase_reg)
                    PH_FAST:
                    begin
                        if (pressed_now)
                        begin
                            if (backoff_reg == '0)
                            begin
                                phase_next   = PH_SLOW;
                                pressed_next = 1'b0;
                                dir_next     = 1'b0;
                            end
                            else
                            begin
                                phase_next = PH_BACK;
                                dir_next   = 1'b1;
                                count_next = '0;
                            end
                        end
                    end
                    PH_BACK:
                    begin
                        count_next = count_inc;
                        if (HCMP_W'(count_inc) >= HCMP_W'(backoff_reg))
                        begin
                            phase_next   = PH_SLOW;
                            pressed_next = 1'b0;
                            dir_next     = 1'b0;
                        end
                    end
                    default:
                    begin
                        if (pressed_now)
                        begin
                            phase_next = PH_DONE;
                            pulse_next = 1'b0;
                            finished   = 1'b1;
                        end
                    end
                endcase
            end
        end
        else if (in_start_reg)
        begin
            phase_next   = PH_FAST;
            dir_next     = 1'b0;
            pressed_next = 1'b0;
            count_next   = '0;
            pulse_next   = 1'b1;
            timer_next   = '0;
        end

        pins = mode_pins(mode_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            timer_reg   <= '0;
            count_reg   <= '0;
            pulse_reg   <= 1'b0;
            pressed_reg <= 1'b0;
            dir_reg     <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            count_reg   <= count_next;
            pulse_reg   <= pulse_next;
            pressed_reg <= pressed_next;
            dir_reg     <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.step_out        <= pulse_next;
            out_reg.dir_out         <= dir_next;
            out_reg.mode_pin_one    <= pins[2];
            out_reg.mode_pin_two    <= pins[1];
            out_reg.mode_pin_three  <= pins[0];
            out_reg.phase           <= phase_next;
            out_reg.edge_accepted   <= accepted;
            out_reg.homing_finished <= finished;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.step_out        = out_reg.step_out;
    assign result.dir_out         = out_reg.dir_out;
    assign result.mode_pin_one    = out_reg.mode_pin_one;
    assign result.mode_pin_two    = out_reg.mode_pin_two;
    assign result.mode_pin_three  = out_reg.mode_pin_three;
    assign result.phase           = out_reg.phase;
    assign result.edge_accepted   = out_reg.edge_accepted;
    assign result.homing_finished = out_reg.homing_finished;

endmodule

`default_nettype wire

// ----- rtl/shs_checker.sv -----
// Port-level assertions for the stepper homing sequencer and the bind that
// attaches them to stepper_homing_sequencer_core. Depends on shs_pkg.
`default_nettype none

module shs_checker
    import shs_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               res_valid,
    input wire logic               res_ready,
    input wire logic               res_step,
    input wire logic               res_pin_one,
    input wire logic               res_pin_two,
    input wire logic               res_pin_three,
    input wire logic [PHASE_W-1:0] res_phase,
    input wire logic               res_finished
);

    // A stalled result request holds its phase and step
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_phase) && $stable(res_step))
        else $error("result changed while stalled");

    // Finishing means done phase with the step line low
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_finished |-> res_phase == PH_DONE && !res_step)
        else $error("finish flag outside done phase");

    // No step pulses while idle or done
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_phase == PH_IDLE || res_phase == PH_DONE) |-> !res_step)
        else $error("step pulse while not homing");

    // Third microstep pin is only set in sixteenth mode, where all are set
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_pin_three |-> res_pin_one && res_pin_two)
        else $error("illegal microstep pin pattern");

endmodule

bind stepper_homing_sequencer_core shs_checker u_shs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_step      (result.step_out),
    .res_pin_one   (result.mode_pin_one),
    .res_pin_two   (result.mode_pin_two),
    .res_pin_three (result.mode_pin_three),
    .res_phase     (result.phase),
    .res_finished  (result.homing_finished)
);

`default_nettype wire
